// ===== design/acmt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acmt_pkg
// Shared constants, codes and the classified command type of the audio
// channel map table.
// ----------------------------------------------------------------------------
package acmt_pkg;

  localparam int INPUT_PORTS  = 4;
  localparam int OUTPUT_PORTS = 4;
  localparam int MAP_ENTRIES  = 16;

  localparam int PORTS_TOTAL = INPUT_PORTS + OUTPUT_PORTS;
  localparam int ALL_SLOTS   = PORTS_TOTAL * MAP_ENTRIES;
  localparam int SLOT_AW     = $clog2(ALL_SLOTS);
  localparam int PORT_AW     = $clog2(PORTS_TOTAL);
  localparam int ENT_AW      = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;
  localparam int ENT_CW      = $clog2(MAP_ENTRIES + 1);
  localparam int CNT_W       = $clog2(MAP_ENTRIES + 2);
  localparam int PC_W        = $clog2(MAP_ENTRIES + 1);
  localparam int MAP_W       = 64;
  localparam int MAX_LISTED  = 16;
  localparam int COUNT_SAT   = 31;

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_GET    = 2'd2,
    ACT_BAD    = 2'd3
  } acmt_action_t;

  localparam logic [1:0] KIND_IN  = 2'd0;
  localparam logic [1:0] KIND_OUT = 2'd1;

  localparam logic [1:0] ST_OK            = 2'd0;
  localparam logic [1:0] ST_NOT_SUPPORTED = 2'd1;
  localparam logic [1:0] ST_BAD_ARGS      = 2'd2;

  // mapping: [15:0] stream index, [31:16] stream channel,
  //          [47:32] cluster offset, [63:48] cluster channel
  typedef struct packed {
    acmt_action_t       action;
    logic               is_input;
    logic [1:0]         chk_st;
    logic [PORT_AW-1:0] pidx;
    logic               present;
    logic [MAP_W-1:0]   mapping;
    logic               last;
  } acmt_cmd_t;

endpackage

// ===== design/acmt_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acmt_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module acmt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/acmt_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acmt_front
// Accepts requests, checks action, descriptor and port, and pushes the
// classified command into the queue.
// ----------------------------------------------------------------------------
module acmt_front import acmt_pkg::*; (
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  action,
  input  logic [1:0]  descriptor_kind,
  input  logic [15:0] port_index,
  input  logic [15:0] map_number,
  input  logic        mapping_present,
  input  logic [63:0] mapping,
  input  logic        last_in_command,
  input  logic        q_full,
  output logic        q_push,
  output acmt_cmd_t   q_cmd
);

  logic [1:0]         loc_st;
  logic [PORT_AW-1:0] pidx;

  // Locate the port table
  always_comb begin
    pidx   = port_index[PORT_AW-1:0];
    loc_st = ST_BAD_ARGS;
    if (descriptor_kind == KIND_IN) begin
      loc_st = (port_index < 16'(INPUT_PORTS)) ? ST_OK : ST_NOT_SUPPORTED;
    end else if (descriptor_kind == KIND_OUT) begin
      loc_st = (port_index < 16'(OUTPUT_PORTS)) ? ST_OK : ST_NOT_SUPPORTED;
      pidx   = PORT_AW'(PORT_AW'(INPUT_PORTS) + port_index[PORT_AW-1:0]);
    end
  end

  // Classify the request
  always_comb begin
    q_cmd.action   = acmt_action_t'(action);
    q_cmd.is_input = (descriptor_kind == KIND_IN);
    q_cmd.pidx     = pidx;
    q_cmd.present  = mapping_present;
    q_cmd.mapping  = mapping;
    q_cmd.last     = last_in_command;
    unique case (acmt_action_t'(action))
      ACT_GET: q_cmd.chk_st = (map_number != 16'd0) ? ST_BAD_ARGS : loc_st;
      ACT_BAD: q_cmd.chk_st = ST_NOT_SUPPORTED;
      default: q_cmd.chk_st = loc_st;
    endcase
  end

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

endmodule

// ===== design/acmt_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acmt_fifo
// Two-entry queue of classified commands between front and back.
// ----------------------------------------------------------------------------
module acmt_fifo import acmt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  acmt_cmd_t push_data,
  output logic      full,
  input  logic      pop,
  output logic      q_valid,
  output acmt_cmd_t q_data
);

  acmt_cmd_t  mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic       do_pop;

  assign full    = (cnt_r == 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign q_data  = mem_r[rd_ptr_r];
  assign do_pop  = pop && q_valid;

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      cnt_r <= 2'(cnt_r + {1'b0, push} - {1'b0, do_pop});
    end
  end

endmodule

// ===== design/acmt_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acmt_back
// Executes commands: scans the port's slots, stages adds and removes,
// commits at command end, lists slots for get, and holds the result register.
// ----------------------------------------------------------------------------
module acmt_back import acmt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  acmt_cmd_t   q_data,
  output logic        q_pop,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [1:0]  o_status,
  output logic        o_present,
  output logic [63:0] o_mapping,
  output logic [4:0]  o_count,
  output logic        o_total,
  output logic        o_last
);

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_CHK, S_FREE, S_DONE, S_CRD, S_CWR, S_CLR, S_EMIT,
    S_GERR, S_GCNT, S_GEMPTY, S_GRD, S_GCHK
  } state_t;

  state_t                  state_r;
  acmt_cmd_t               cur_r;
  logic [ENT_CW-1:0]       j_r;
  logic [1:0]              cst_r;
  logic [CNT_W-1:0]        cnt_r;
  logic [MAP_ENTRIES-1:0]  stg_wr_r;
  logic [MAP_ENTRIES-1:0]  stg_rsv_r;
  logic [MAP_ENTRIES-1:0]  stg_clr_r;
  logic [MAP_ENTRIES-1:0]  valid_r [PORTS_TOTAL];
  logic [4:0]              gcount_r;
  logic [4:0]              glim_r;
  logic [4:0]              glisted_r;
  logic                    out_valid_r;
  logic [1:0]              out_status_r;
  logic                    out_present_r;
  logic [63:0]             out_map_r;
  logic [4:0]              out_count_r;
  logic                    out_total_r;
  logic                    out_last_r;

  logic [ENT_AW-1:0]       je;
  logic                    j_end;
  logic [MAP_ENTRIES-1:0]  pv;
  logic                    sv;
  logic [SLOT_AW-1:0]      slot_addr;
  logic [63:0]             map_rdata;
  logic [63:0]             stg_rdata;
  logic                    map_re;
  logic                    map_we;
  logic                    stg_re;
  logic                    stg_we;
  logic [ENT_AW-1:0]       stg_waddr;
  logic                    eq;
  logic                    clash;
  logic                    free_found;
  logic [ENT_AW-1:0]       free_j;
  logic [PC_W-1:0]         pc;
  logic [4:0]              pc_sat;
  logic [1:0]              st_upd;
  logic [CNT_W-1:0]        cnt_inc;
  logic                    out_free;
  logic                    glast;
  logic                    emit;

  assign je        = j_r[ENT_AW-1:0];
  assign j_end     = (j_r == ENT_CW'(MAP_ENTRIES - 1));
  assign pv        = valid_r[cur_r.pidx];
  assign sv        = pv[je];
  assign slot_addr = SLOT_AW'(SLOT_AW'(cur_r.pidx) * SLOT_AW'(MAP_ENTRIES) + SLOT_AW'(je));
  assign out_free  = !out_valid_r || out_tready;
  assign q_pop     = (state_r == S_IDLE);
  assign glast     = (5'(glisted_r + 5'd1) == glim_r);

  // Load a new result this cycle
  assign emit = out_free && (state_r == S_EMIT || state_r == S_GERR ||
                             state_r == S_GEMPTY || state_r == S_GCHK);

  // Compare the slot read back against the current mapping
  assign eq    = (map_rdata == cur_r.mapping);
  assign clash = cur_r.is_input ? (map_rdata[63:32] == cur_r.mapping[63:32])
                                : (map_rdata[31:0] == cur_r.mapping[31:0]);

  // Status and item count after the incoming add or remove item
  assign st_upd  = (cst_r == ST_OK && q_data.chk_st != ST_OK) ? q_data.chk_st : cst_r;
  assign cnt_inc = CNT_W'(cnt_r + 1'b1);

  // Find the first slot neither valid nor reserved
  always_comb begin
    free_found = 1'b0;
    free_j     = '0;
    for (int i = MAP_ENTRIES - 1; i >= 0; i--) begin
      if (!pv[i] && !stg_rsv_r[i]) begin
        free_found = 1'b1;
        free_j     = ENT_AW'(i);
      end
    end
  end

  // Count valid slots of the port
  always_comb begin
    pc = '0;
    for (int i = 0; i < MAP_ENTRIES; i++) begin
      pc = PC_W'(pc + PC_W'(pv[i]));
    end
    pc_sat = (pc > PC_W'(COUNT_SAT)) ? 5'(COUNT_SAT) : 5'(pc);
  end

  // Memory strobes
  assign map_re    = (state_r == S_RD) || (state_r == S_GRD && sv);
  assign map_we    = (state_r == S_CWR);
  assign stg_re    = (state_r == S_CRD);
  assign stg_we    = (state_r == S_CHK && cur_r.action == ACT_ADD && sv && !eq && clash) ||
                     (state_r == S_FREE && free_found);
  assign stg_waddr = (state_r == S_FREE) ? free_j : je;

  acmt_ram #(.WIDTH(MAP_W), .DEPTH(ALL_SLOTS)) u_map_ram (
    .clk   (clk),
    .we    (map_we),
    .waddr (slot_addr),
    .wdata (stg_rdata),
    .re    (map_re),
    .raddr (slot_addr),
    .rdata (map_rdata)
  );

  acmt_ram #(.WIDTH(MAP_W), .DEPTH(MAP_ENTRIES)) u_stg_ram (
    .clk   (clk),
    .we    (stg_we),
    .waddr (stg_waddr),
    .wdata (cur_r.mapping),
    .re    (stg_re),
    .raddr (je),
    .rdata (stg_rdata)
  );

  // Sequencer and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      j_r         <= '0;
      cst_r       <= ST_OK;
      cnt_r       <= '0;
      stg_wr_r    <= '0;
      stg_rsv_r   <= '0;
      stg_clr_r   <= '0;
      glisted_r   <= '0;
      out_valid_r <= 1'b0;
      for (int p = 0; p < PORTS_TOTAL; p++) begin
        valid_r[p] <= '0;
      end
    end else begin
      if (out_valid_r && out_tready && !emit) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            cur_r     <= q_data;
            j_r       <= '0;
            glisted_r <= '0;
            if (q_data.action == ACT_GET) begin
              state_r <= (q_data.chk_st != ST_OK) ? S_GERR : S_GCNT;
            end else begin
              cst_r <= st_upd;
              if (st_upd == ST_OK && q_data.present) begin
                cnt_r <= cnt_inc;
                if (cnt_inc > CNT_W'(MAP_ENTRIES)) begin
                  cst_r   <= ST_BAD_ARGS;
                  state_r <= S_DONE;
                end else begin
                  state_r <= S_RD;
                end
              end else begin
                state_r <= S_DONE;
              end
            end
          end
        end
        S_RD: state_r <= S_CHK;
        S_CHK: begin
          if (cur_r.action == ACT_ADD) begin
            if (sv && eq) begin
              state_r <= S_DONE;
            end else if (sv && clash) begin
              stg_wr_r[je] <= 1'b1;
              state_r      <= S_DONE;
            end else if (j_end) begin
              state_r <= S_FREE;
            end else begin
              j_r     <= ENT_CW'(j_r + 1'b1);
              state_r <= S_RD;
            end
          end else begin
            if (sv && eq) begin
              stg_clr_r[je] <= 1'b1;
              state_r       <= S_DONE;
            end else if (j_end) begin
              cst_r   <= ST_BAD_ARGS;
              state_r <= S_DONE;
            end else begin
              j_r     <= ENT_CW'(j_r + 1'b1);
              state_r <= S_RD;
            end
          end
        end
        S_FREE: begin
          if (free_found) begin
            stg_wr_r[free_j]  <= 1'b1;
            stg_rsv_r[free_j] <= 1'b1;
          end else begin
            cst_r <= ST_NOT_SUPPORTED;
          end
          state_r <= S_DONE;
        end
        S_DONE: begin
          j_r <= '0;
          if (cur_r.last) begin
            state_r <= (cst_r == ST_OK) ? S_CRD : S_EMIT;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_CRD: begin
          if (stg_wr_r[je]) begin
            state_r <= S_CWR;
          end else if (j_end) begin
            state_r <= S_CLR;
          end else begin
            j_r <= ENT_CW'(j_r + 1'b1);
          end
        end
        S_CWR: begin
          valid_r[cur_r.pidx][je] <= 1'b1;
          if (j_end) begin
            state_r <= S_CLR;
          end else begin
            j_r     <= ENT_CW'(j_r + 1'b1);
            state_r <= S_CRD;
          end
        end
        S_CLR: begin
          valid_r[cur_r.pidx] <= pv & ~stg_clr_r;
          state_r             <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_r   <= 1'b1;
            out_status_r  <= cst_r;
            out_present_r <= 1'b0;
            out_map_r     <= '0;
            out_count_r   <= '0;
            out_total_r   <= 1'b0;
            out_last_r    <= 1'b1;
            stg_wr_r      <= '0;
            stg_rsv_r     <= '0;
            stg_clr_r     <= '0;
            cst_r         <= ST_OK;
            cnt_r         <= '0;
            state_r       <= S_IDLE;
          end
        end
        S_GERR: begin
          if (out_free) begin
            out_valid_r   <= 1'b1;
            out_status_r  <= cur_r.chk_st;
            out_present_r <= 1'b0;
            out_map_r     <= '0;
            out_count_r   <= '0;
            out_total_r   <= 1'b0;
            out_last_r    <= 1'b1;
            state_r       <= S_IDLE;
          end
        end
        S_GCNT: begin
          gcount_r <= pc_sat;
          glim_r   <= (pc_sat > 5'(MAX_LISTED)) ? 5'(MAX_LISTED) : pc_sat;
          state_r  <= (pc_sat == 5'd0) ? S_GEMPTY : S_GRD;
        end
        S_GEMPTY: begin
          if (out_free) begin
            out_valid_r   <= 1'b1;
            out_status_r  <= ST_OK;
            out_present_r <= 1'b0;
            out_map_r     <= '0;
            out_count_r   <= '0;
            out_total_r   <= 1'b1;
            out_last_r    <= 1'b1;
            state_r       <= S_IDLE;
          end
        end
        S_GRD: begin
          if (sv) begin
            state_r <= S_GCHK;
          end else begin
            j_r <= ENT_CW'(j_r + 1'b1);
          end
        end
        S_GCHK: begin
          if (out_free) begin
            out_valid_r   <= 1'b1;
            out_status_r  <= ST_OK;
            out_present_r <= 1'b1;
            out_map_r     <= map_rdata;
            out_count_r   <= gcount_r;
            out_total_r   <= 1'b1;
            out_last_r    <= glast;
            glisted_r     <= 5'(glisted_r + 5'd1);
            j_r           <= ENT_CW'(j_r + 1'b1);
            state_r       <= glast ? S_IDLE : S_GRD;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign o_status   = out_status_r;
  assign o_present  = out_present_r;
  assign o_mapping  = out_map_r;
  assign o_count    = out_count_r;
  assign o_total    = out_total_r;
  assign o_last     = out_last_r;

  // Item count stops one past the batch limit
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAP_ENTRIES + 1))
    else $error("item count beyond batch limit");

  // Commit writes only slots that were staged
  a_commit_staged: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CWR |-> stg_wr_r[je])
    else $error("commit of an unstaged slot");

  // Listing never runs past its limit
  a_list_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_GCHK |-> glisted_r < glim_r)
    else $error("get listing overran");

  // A staging write never happens outside an add
  a_stage_add: assert property (@(posedge clk) disable iff (!rst_n)
    stg_we |-> cur_r.action == ACT_ADD)
    else $error("staging write outside add");

endmodule

// ===== design/audio_channel_map_table_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// audio_channel_map_table_core
// Per-port audio channel map table with staged add/remove and get listing.
// ----------------------------------------------------------------------------
// Add/remove item: the back end scans the port's slots through the mapping RAM read port,
//   reading and then checking each slot; command end reads every slot of the staging RAM,
//   writes each staged slot into the table, clears the removed slots and loads the result.
// Get: one result for an error, one for an empty port, else one result per listed valid slot.
// One item at a time in the back end, plus any result stall; a two-entry queue buffers.
// Reset (rst_n low, synchronous) clears valid bits, staging and status; RAMs keep data.
module audio_channel_map_table_core import acmt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [15:0] port_index, [31:16] map_number, [47:32] stream_index,
  // [63:48] stream_channel, [79:64] cluster_offset, [95:80] cluster_channel
  input  logic [95:0] in_tdata,
  // [1:0] action, [3:2] descriptor_kind, [4] mapping_present
  input  logic [4:0]  in_tuser,
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [1:0] status, [17:2] out_stream_index, [33:18] out_stream_channel,
  // [49:34] out_cluster_offset, [65:50] out_cluster_channel,
  // [70:66] entry_count, [71] map_total
  output logic [71:0] out_tdata,
  // [0] entry_present
  output logic [0:0]  out_tuser,
  output logic        out_tlast
);

  acmt_cmd_t   push_cmd;
  acmt_cmd_t   q_data;
  logic        q_push;
  logic        q_full;
  logic        q_valid;
  logic        q_pop;
  logic [1:0]  o_status;
  logic        o_present;
  logic [63:0] o_mapping;
  logic [4:0]  o_count;
  logic        o_total;
  logic        o_last;

  acmt_front u_front (
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .action          (in_tuser[1:0]),
    .descriptor_kind (in_tuser[3:2]),
    .port_index      (in_tdata[15:0]),
    .map_number      (in_tdata[31:16]),
    .mapping_present (in_tuser[4]),
    .mapping         (in_tdata[95:32]),
    .last_in_command (in_tlast),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_cmd           (push_cmd)
  );

  acmt_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .q_valid   (q_valid),
    .q_data    (q_data)
  );

  acmt_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_data     (q_data),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .o_status   (o_status),
    .o_present  (o_present),
    .o_mapping  (o_mapping),
    .o_count    (o_count),
    .o_total    (o_total),
    .o_last     (o_last)
  );

  // Pack the result
  assign out_tdata = {o_total, o_count, o_mapping, o_status};
  assign out_tuser = o_present;
  assign out_tlast = o_last;

endmodule

// ===== tb/sv/acmt_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acmt_checker
// Watches both stream channels of the channel map table, predicts the results
// of every accepted request and compares them in order with what comes out.
// ----------------------------------------------------------------------------
module acmt_checker import acmt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [95:0] in_tdata,
  input  logic [4:0]  in_tuser,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [71:0] out_tdata,
  input  logic [0:0]  out_tuser,
  input  logic        out_tlast,
  output int          fail_count,
  output int          pending,
  output int          results_seen
);

  typedef struct packed {
    logic [1:0]  status;
    logic        present;
    logic [63:0] mapping;
    logic [4:0]  count;
    logic        total;
    logic        last;
  } map_result_t;

  logic [63:0] table_map [ALL_SLOTS];
  logic        table_vld [ALL_SLOTS];
  logic [63:0] stage_map [MAP_ENTRIES];
  logic        stage_wr  [MAP_ENTRIES];
  logic        stage_rsv [MAP_ENTRIES];
  logic        stage_clr [MAP_ENTRIES];
  logic [1:0]  cmd_status;
  int          cmd_items;
  map_result_t result_q [$];

  assign pending = result_q.size();

  // Resolve a kind and port to a slot base, returning the port check status.
  function automatic logic [1:0] port_base(input logic [1:0] kind,
                                           input logic [15:0] port, output int base);
    base = 0;
    if (kind == KIND_IN) begin
      if (port >= INPUT_PORTS) return ST_NOT_SUPPORTED;
      base = port * MAP_ENTRIES;
      return ST_OK;
    end
    if (kind == KIND_OUT) begin
      if (port >= OUTPUT_PORTS) return ST_NOT_SUPPORTED;
      base = (INPUT_PORTS + port) * MAP_ENTRIES;
      return ST_OK;
    end
    return ST_BAD_ARGS;
  endfunction

  function automatic logic [1:0] stage_add(input int base, input logic is_in,
                                           input logic [63:0] m);
    logic clash;
    for (int j = 0; j < MAP_ENTRIES; j++) begin
      if (!table_vld[base+j]) continue;
      if (table_map[base+j] == m) return ST_OK;
      clash = is_in ? (m[63:32] == table_map[base+j][63:32])
                    : (m[31:0] == table_map[base+j][31:0]);
      if (clash) begin
        stage_map[j] = m;
        stage_wr[j]  = 1'b1;
        return ST_OK;
      end
    end
    for (int j = 0; j < MAP_ENTRIES; j++) begin
      if (!table_vld[base+j] && !stage_rsv[j]) begin
        stage_rsv[j] = 1'b1;
        stage_map[j] = m;
        stage_wr[j]  = 1'b1;
        return ST_OK;
      end
    end
    return ST_NOT_SUPPORTED;
  endfunction

  function automatic logic [1:0] stage_remove(input int base, input logic [63:0] m);
    for (int j = 0; j < MAP_ENTRIES; j++) begin
      if (table_vld[base+j] && table_map[base+j] == m) begin
        stage_clr[j] = 1'b1;
        return ST_OK;
      end
    end
    return ST_BAD_ARGS;
  endfunction

  // Apply one request to the predicted table and queue its results.
  task automatic predict_request(input logic [95:0] d, input logic [4:0] u,
                                 input logic lst);
    acmt_action_t act;
    logic [1:0]   kind, st;
    logic [15:0]  port, mapnum;
    logic [63:0]  m;
    int           base, cnt, listed;
    map_result_t  r;
    act    = acmt_action_t'(u[1:0]);
    kind   = u[3:2];
    port   = d[15:0];
    mapnum = d[31:16];
    m      = d[95:32];
    if (act == ACT_GET) begin
      st = (mapnum != 0) ? ST_BAD_ARGS : port_base(kind, port, base);
      r = '0;
      if (st != ST_OK) begin
        r.status = st;
        r.last   = 1'b1;
        result_q.push_back(r);
        return;
      end
      cnt = 0;
      listed = 0;
      for (int j = 0; j < MAP_ENTRIES; j++) if (table_vld[base+j]) cnt++;
      if (cnt > COUNT_SAT) cnt = COUNT_SAT;
      for (int j = 0; j < MAP_ENTRIES && listed < MAX_LISTED; j++) begin
        if (!table_vld[base+j]) continue;
        r = '0;
        r.present = 1'b1;
        r.mapping = table_map[base+j];
        r.count   = 5'(cnt);
        r.total   = 1'b1;
        result_q.push_back(r);
        listed++;
      end
      if (listed == 0) begin
        r = '0;
        r.total = 1'b1;
        result_q.push_back(r);
      end
      result_q[$].last = 1'b1;
      return;
    end
    st = (act == ACT_BAD) ? ST_NOT_SUPPORTED : port_base(kind, port, base);
    if (cmd_status == ST_OK && st != ST_OK) cmd_status = st;
    if (cmd_status == ST_OK && u[4]) begin
      if (cmd_items < 255) cmd_items++;
      if (cmd_items > MAP_ENTRIES) cmd_status = ST_BAD_ARGS;
      else if (act == ACT_ADD) cmd_status = stage_add(base, kind == KIND_IN, m);
      else cmd_status = stage_remove(base, m);
    end
    if (!lst) return;
    // Commit writes, then clears, to the port named by the closing request.
    if (cmd_status == ST_OK) begin
      for (int j = 0; j < MAP_ENTRIES; j++)
        if (stage_wr[j]) begin
          table_map[base+j] = stage_map[j];
          table_vld[base+j] = 1'b1;
        end
      for (int j = 0; j < MAP_ENTRIES; j++)
        if (stage_clr[j]) table_vld[base+j] = 1'b0;
    end
    r = '0;
    r.status = cmd_status;
    r.last   = 1'b1;
    result_q.push_back(r);
    for (int j = 0; j < MAP_ENTRIES; j++) begin
      stage_wr[j]  = 1'b0;
      stage_rsv[j] = 1'b0;
      stage_clr[j] = 1'b0;
    end
    cmd_status = ST_OK;
    cmd_items  = 0;
  endtask

  always @(posedge clk) begin
    map_result_t got, want;
    if (!rst_n) begin
      for (int i = 0; i < ALL_SLOTS; i++) table_vld[i] = 1'b0;
      for (int j = 0; j < MAP_ENTRIES; j++) begin
        stage_wr[j]  = 1'b0;
        stage_rsv[j] = 1'b0;
        stage_clr[j] = 1'b0;
      end
      cmd_status = ST_OK;
      cmd_items  = 0;
      result_q.delete();
      fail_count   = 0;
      results_seen = 0;
    end else begin
      // Check the result first: it was produced from state before this request.
      if (out_tvalid && out_tready) begin
        got.status  = out_tdata[1:0];
        got.present = out_tuser[0];
        got.mapping = out_tdata[65:2];
        got.count   = out_tdata[70:66];
        got.total   = out_tdata[71];
        got.last    = out_tlast;
        results_seen++;
        if (result_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result, expected none, actual %h", $realtime, got);
        end else begin
          want = result_q.pop_front();
          if (got !== want) begin
            fail_count++;
            $display("%0t: result expected st=%0d pr=%0b map=%h cnt=%0d tot=%0b lst=%0b",
                     $realtime, want.status, want.present, want.mapping, want.count,
                     want.total, want.last);
            $display("%0t: result actual   st=%0d pr=%0b map=%h cnt=%0d tot=%0b lst=%0b",
                     $realtime, got.status, got.present, got.mapping, got.count,
                     got.total, got.last);
          end
        end
      end
      if (in_tvalid && in_tready) predict_request(in_tdata, in_tuser, in_tlast);
    end
  end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives add, remove and get requests into the channel map table with random
// gaps on both sides; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
  import acmt_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [95:0] in_tdata;
  logic [4:0]  in_tuser;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [71:0] out_tdata;
  logic [0:0]  out_tuser;
  logic        out_tlast;
  int          fail_count;
  int          pending;
  int          results_seen;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          sent;
  int          quiet_cycles;
  logic [63:0] pool [8];

  localparam int QUIET_LIMIT = 20000;

  audio_channel_map_table_core u_top (.*);

  acmt_checker u_chk (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver stalls at random.
  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog on cycles with no handshake.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("audio_channel_map_table_core: mismatch");
      $finish;
    end
  end

  // Send one request, holding it until accepted; idle beforehand at random.
  task automatic send(input acmt_action_t act, input logic [1:0] kind,
                      input logic [15:0] port, input logic [15:0] mapnum,
                      input logic pres, input logic [63:0] m, input logic lst);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {m, mapnum, port};
    in_tuser  <= {pres, kind, act};
    in_tlast  <= lst;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
  endtask

  // Mapping drawn mostly from a small pool so that matches and clashes occur.
  function automatic logic [63:0] pick_map();
    logic [63:0] m;
    m = pool[$urandom_range(7)];
    case ($urandom_range(5))
      0: m = {$urandom, $urandom};
      1: m[15:0] = 16'($urandom_range(3));
      2: m[63:48] = 16'($urandom_range(3));
      default: ;
    endcase
    return m;
  endfunction

  task automatic random_command();
    acmt_action_t act;
    logic [1:0]  kind;
    logic [15:0] port;
    int          n;
    int          r;
    r = $urandom_range(99);
    act = (r < 45) ? ACT_ADD : (r < 70) ? ACT_REMOVE : (r < 95) ? ACT_GET : ACT_BAD;
    kind = ($urandom_range(19) == 0) ? 2'($urandom_range(3, 2)) : 2'($urandom_range(1));
    port = ($urandom_range(19) == 0) ? 16'($urandom) : 16'($urandom_range(3));
    if (act == ACT_GET) begin
      send(act, kind, port, ($urandom_range(15) == 0) ? 16'($urandom) : 16'd0,
           1'($urandom), {$urandom, $urandom}, 1'($urandom));
      return;
    end
    n = ($urandom_range(19) == 0) ? $urandom_range(17, 20) : $urandom_range(1, 5);
    for (int i = 0; i < n; i++)
      send(act, kind, port, 16'($urandom), ($urandom_range(9) != 0), pick_map(),
           i == n - 1);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tuser      = '0;
    in_tlast      = 1'b0;
    rst_n         = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    sent          = 0;
    for (int i = 0; i < 8; i++) pool[i] = {$urandom, $urandom};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty get, extremes of fields, overflow, errors of each kind.
    send(ACT_GET, KIND_IN, 16'd0, 16'd0, 1'b0, '0, 1'b1);
    send(ACT_ADD, KIND_IN, 16'd0, 16'd0, 1'b1, '1, 1'b0);
    send(ACT_ADD, KIND_IN, 16'd0, 16'hffff, 1'b1, '0, 1'b1);
    send(ACT_ADD, KIND_OUT, 16'd3, 16'd0, 1'b1, pool[0], 1'b1);
    send(ACT_ADD, KIND_OUT, 16'd3, 16'd0, 1'b1, pool[0], 1'b1);
    send(ACT_ADD, KIND_OUT, 16'd3, 16'd0, 1'b1, {16'd9, 16'd9, pool[0][31:0]}, 1'b1);
    send(ACT_GET, KIND_IN, 16'd0, 16'd0, 1'b0, '0, 1'b0);
    send(ACT_GET, KIND_OUT, 16'd3, 16'd0, 1'b0, '0, 1'b1);
    send(ACT_GET, KIND_IN, 16'd0, 16'd1, 1'b0, '0, 1'b1);
    send(ACT_GET, KIND_IN, 16'd4, 16'd0, 1'b0, '0, 1'b1);
    send(ACT_GET, 2'd2, 16'd0, 16'd0, 1'b0, '0, 1'b1);
    send(ACT_ADD, KIND_OUT, 16'hffff, 16'd0, 1'b1, '0, 1'b1);
    send(ACT_REMOVE, 2'd3, 16'd0, 16'd0, 1'b0, '0, 1'b1);
    send(ACT_REMOVE, KIND_IN, 16'd0, 16'd0, 1'b1, pool[1], 1'b1);
    send(ACT_REMOVE, KIND_IN, 16'd0, 16'd0, 1'b1, '1, 1'b1);
    send(ACT_BAD, KIND_IN, 16'd0, 16'd0, 1'b1, '0, 1'b1);
    send(ACT_ADD, KIND_IN, 16'd0, 16'd0, 1'b0, '0, 1'b1);
    // A 17-item batch overflows, 16 items fill input port 1, then one more distinct add finds it full.
    for (int i = 0; i < 17; i++)
      send(ACT_ADD, KIND_IN, 16'd1, 16'd0, 1'b1, {16'(i), 16'(i), 32'(i)}, i == 16);
    for (int i = 0; i < 16; i++)
      send(ACT_ADD, KIND_IN, 16'd1, 16'd0, 1'b1, {16'(i), 16'(i), 32'(i)}, i == 15);
    send(ACT_ADD, KIND_IN, 16'd1, 16'd0, 1'b1, {16'd99, 16'd99, 32'd0}, 1'b1);
    send(ACT_GET, KIND_IN, 16'd1, 16'd0, 1'b0, '0, 1'b1);
    wait_drained();

    // Random part in three idling phases.
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 17 : (ph == 1) ? 64 : 0;
      recv_idle_pct = (ph == 0) ? 64 : (ph == 1) ? 17 : 0;
      while (sent < (ph + 1) * 120) begin
        random_command();
        if ($urandom_range(29) == 0) wait_drained();
      end
    end

    wait_drained();
    repeat (200) @(posedge clk);
    $display("Covered %0d requests and %0d results over add, remove, get and errors.",
             sent, results_seen);
    if (fail_count == 0 && pending == 0) $display("audio_channel_map_table_core: match");
    else $display("audio_channel_map_table_core: mismatch");
    $finish;
  end

endmodule
